### rtl/rcsr_pkg.sv
// Package for the RV32 CSR trap unit: payload types, CSR codes, masks.
// No dependencies.
`default_nettype none
package rcsr_pkg;
	typedef struct packed {
		logic [1:0]  cmd;
		logic [11:0] csr_number;
		logic [1:0]  write_op;
		logic [31:0] data;
		logic [31:0] pc;
		logic [2:0]  event_kind;
		logic        irq_take;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_pending;
		logic [1:0]  trap_taken;
		logic [31:0] trap_pc;
		logic        return_taken;
		logic [31:0] return_pc;
		logic [1:0]  privilege_now;
		logic [31:0] status_now;
		logic [31:0] satp_now;
	} rsp_t;

	localparam logic [1:0] CMD_READ   = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_RETIRE = 2'd2;

	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] EV_ECALL  = 3'd1;
	localparam logic [2:0] EV_IFAULT = 3'd2;
	localparam logic [2:0] EV_LFAULT = 3'd3;
	localparam logic [2:0] EV_SFAULT = 3'd4;
	localparam logic [2:0] EV_ILL    = 3'd5;
	localparam logic [2:0] EV_MRET   = 3'd6;
	localparam logic [2:0] EV_SRET   = 3'd7;

	localparam logic [1:0] TRAP_NONE = 2'd0;
	localparam logic [1:0] TRAP_M    = 2'd1;
	localparam logic [1:0] TRAP_S    = 2'd2;

	localparam logic [1:0] PRIV_U = 2'd0;
	localparam logic [1:0] PRIV_S = 2'd1;
	localparam logic [1:0] PRIV_M = 2'd3;

	localparam logic [11:0] A_SSTATUS  = 12'h100;
	localparam logic [11:0] A_SIE      = 12'h104;
	localparam logic [11:0] A_STVEC    = 12'h105;
	localparam logic [11:0] A_SSCRATCH = 12'h140;
	localparam logic [11:0] A_SEPC     = 12'h141;
	localparam logic [11:0] A_SCAUSE   = 12'h142;
	localparam logic [11:0] A_STVAL    = 12'h143;
	localparam logic [11:0] A_SIP      = 12'h144;
	localparam logic [11:0] A_SATP     = 12'h180;
	localparam logic [11:0] A_MSTATUS  = 12'h300;
	localparam logic [11:0] A_MISA     = 12'h301;
	localparam logic [11:0] A_MEDELEG  = 12'h302;
	localparam logic [11:0] A_MIDELEG  = 12'h303;
	localparam logic [11:0] A_MIE      = 12'h304;
	localparam logic [11:0] A_MTVEC    = 12'h305;
	localparam logic [11:0] A_MSCRATCH = 12'h340;
	localparam logic [11:0] A_MEPC     = 12'h341;
	localparam logic [11:0] A_MCAUSE   = 12'h342;
	localparam logic [11:0] A_MTVAL    = 12'h343;
	localparam logic [11:0] A_MIP      = 12'h344;

	localparam logic [31:0] MISA_VALUE    = 32'h40141103;
	localparam logic [31:0] MSTATUS_WMASK = 32'h807FF9BB;
	localparam logic [31:0] S_STATUS_BITS = 32'h800DE133;
	localparam logic [31:0] M_INT_BITS    = 32'h00000bbb;
	localparam logic [31:0] S_INT_BITS    = 32'h00000333;
	localparam logic [31:0] TVEC_BASE     = 32'hfffffffc;
	localparam logic [31:0] CODE_MASK     = 32'h7fffffff;
endpackage
`default_nettype wire

### rtl/rcsr_req_if.sv
// Valid/ready request channel interface for the CSR trap unit.
// Depends on rcsr_pkg.
`default_nettype none
interface rcsr_req_if;
	logic valid;
	logic ready;
	rcsr_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/rcsr_rsp_if.sv
// Valid/ready result channel interface for the CSR trap unit.
// Depends on rcsr_pkg.
`default_nettype none
interface rcsr_rsp_if;
	logic valid;
	logic ready;
	rcsr_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/rv32_csr_trap_unit.sv
// Top level of the RV32 M/S/U CSR and trap unit.
// Depends on rcsr_pkg, rcsr_req_if, rcsr_rsp_if.
//
// channel | dir | payload
// req     | in  | cmd, csr_number, write_op, data, pc, event_kind, irq_take
// rsp     | out | read_data .. satp_now, one beat per request beat
//
// One beat per cycle while the output is not held. Each accepted beat updates
// the CSR state at its edge and registers the result in the output register,
// from which it leaves. The output stage holds while the sink stalls and takes
// the next beat in the same cycle the held one drains. arst_n clears
// privilege to machine, all CSRs to zero and the output valid.
`default_nettype none
module rv32_csr_trap_unit #(
	parameter int CSR_COUNT = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	rcsr_req_if.sink req,
	rcsr_rsp_if.source rsp
);
	localparam int IW = $clog2(CSR_COUNT);

	// slot positions in the store
	localparam logic [IW-1:0] S_MSTATUS = IW'(0);
	localparam logic [IW-1:0] S_MIE = IW'(1);
	localparam logic [IW-1:0] S_MIP = IW'(2);
	localparam logic [IW-1:0] S_MIDELEG = IW'(3);
	localparam logic [IW-1:0] S_MEDELEG = IW'(4);
	localparam logic [IW-1:0] S_MTVEC = IW'(5);
	localparam logic [IW-1:0] S_STVEC = IW'(6);
	localparam logic [IW-1:0] S_MEPC = IW'(7);
	localparam logic [IW-1:0] S_SEPC = IW'(8);
	localparam logic [IW-1:0] S_MCAUSE = IW'(9);
	localparam logic [IW-1:0] S_SCAUSE = IW'(10);
	localparam logic [IW-1:0] S_MTVAL = IW'(11);
	localparam logic [IW-1:0] S_STVAL = IW'(12);
	localparam logic [IW-1:0] S_SATP = IW'(13);
	localparam logic [IW-1:0] S_MSCRATCH = IW'(14);
	localparam logic [IW-1:0] S_SSCRATCH = IW'(15);

	logic [31:0] csr_q [CSR_COUNT];
	logic [1:0] priv_q;
	logic out_valid_q;
	rcsr_pkg::rsp_t out_q;

	rcsr_pkg::req_t r;
	logic accept;
	logic [31:0] ms, pend, mid, mdel;
	logic m_en, s_en, msw, mt, me, ssw, st, se, m_any, s_any;
	logic slot_ok;
	logic [IW-1:0] slot;
	logic [31:0] rd_val, wval;
	logic intr;
	logic [4:0] code;
	logic [31:0] tval, tvec, tpc;
	logic [1:0] trap, priv_n;
	logic ret;
	logic [31:0] rpc, ms_n;
	logic [31:0] nx [CSR_COUNT];

	assign r = req.payload;
	// take a beat whenever the output register is free or drains now
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept = req.valid && req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.payload = out_q;

	always_comb begin
		slot_ok = 1'b1;
		slot = S_MSTATUS;
		case (r.csr_number)
			rcsr_pkg::A_MSTATUS: slot = S_MSTATUS;
			rcsr_pkg::A_MIE: slot = S_MIE;
			rcsr_pkg::A_MIP: slot = S_MIP;
			rcsr_pkg::A_MIDELEG: slot = S_MIDELEG;
			rcsr_pkg::A_MEDELEG: slot = S_MEDELEG;
			rcsr_pkg::A_MTVEC: slot = S_MTVEC;
			rcsr_pkg::A_STVEC: slot = S_STVEC;
			rcsr_pkg::A_MEPC: slot = S_MEPC;
			rcsr_pkg::A_SEPC: slot = S_SEPC;
			rcsr_pkg::A_MCAUSE: slot = S_MCAUSE;
			rcsr_pkg::A_SCAUSE: slot = S_SCAUSE;
			rcsr_pkg::A_MTVAL: slot = S_MTVAL;
			rcsr_pkg::A_STVAL: slot = S_STVAL;
			rcsr_pkg::A_SATP: slot = S_SATP;
			rcsr_pkg::A_MSCRATCH: slot = S_MSCRATCH;
			rcsr_pkg::A_SSCRATCH: slot = S_SSCRATCH;
			default: slot_ok = 1'b0;
		endcase
	end

	always_comb begin
		case (r.csr_number)
			rcsr_pkg::A_SSTATUS: rd_val = csr_q[S_MSTATUS] & rcsr_pkg::S_STATUS_BITS;
			rcsr_pkg::A_SIE: rd_val = csr_q[S_MIE] & rcsr_pkg::S_INT_BITS;
			rcsr_pkg::A_SIP: rd_val = csr_q[S_MIP] & rcsr_pkg::S_INT_BITS;
			rcsr_pkg::A_MISA: rd_val = rcsr_pkg::MISA_VALUE;
			default: rd_val = slot_ok ? csr_q[slot] : 32'd0;
		endcase
		case (r.write_op)
			rcsr_pkg::OP_SET: wval = rd_val | r.data;
			rcsr_pkg::OP_CLEAR: wval = rd_val & ~r.data;
			default: wval = r.data;
		endcase
	end

	// interrupt evaluation on the state before the beat
	always_comb begin
		ms = csr_q[S_MSTATUS];
		pend = csr_q[S_MIP] & csr_q[S_MIE];
		mid = csr_q[S_MIDELEG];
		mdel = csr_q[S_MEDELEG];
		m_en = priv_q != rcsr_pkg::PRIV_M || ms[3];
		s_en = priv_q == rcsr_pkg::PRIV_U || (priv_q == rcsr_pkg::PRIV_S && ms[1]);
		msw = pend[3] && !mid[3] && m_en;
		mt = pend[7] && !mid[7] && m_en;
		me = pend[11] && !mid[11] && m_en;
		ssw = ((pend[3] && mid[3]) || pend[1]) && s_en;
		st = ((pend[7] && mid[7]) || pend[5]) && s_en;
		se = ((pend[11] && mid[11]) || pend[9]) && s_en;
		m_any = msw || mt || me;
		s_any = ssw || st || se;
	end

	always_comb begin
		intr = 1'b0;
		code = 5'd0;
		tval = 32'd0;
		trap = rcsr_pkg::TRAP_NONE;
		if (r.cmd == rcsr_pkg::CMD_RETIRE) begin
			if (r.irq_take && (m_any || s_any)) begin
				intr = 1'b1;
				if (m_any) begin
					trap = rcsr_pkg::TRAP_M;
					code = msw ? 5'd3 : mt ? 5'd7 : 5'd11;
				end else begin
					trap = rcsr_pkg::TRAP_S;
					code = se ? 5'd9 : st ? 5'd5 : 5'd1;
				end
			end else if (r.event_kind >= rcsr_pkg::EV_ECALL && r.event_kind <= rcsr_pkg::EV_ILL)
			begin
				case (r.event_kind)
					rcsr_pkg::EV_ECALL: code = priv_q == rcsr_pkg::PRIV_U ? 5'd8 :
						priv_q == rcsr_pkg::PRIV_S ? 5'd9 : 5'd11;
					rcsr_pkg::EV_IFAULT: code = 5'd12;
					rcsr_pkg::EV_LFAULT: code = 5'd13;
					rcsr_pkg::EV_SFAULT: code = 5'd15;
					default: code = 5'd2;
				endcase
				if (r.event_kind != rcsr_pkg::EV_ECALL) tval = r.data;
				trap = (priv_q != rcsr_pkg::PRIV_M && code != 5'd11 && mdel[code]) ?
					rcsr_pkg::TRAP_S : rcsr_pkg::TRAP_M;
			end
		end
		tvec = (trap == rcsr_pkg::TRAP_S) ? csr_q[S_STVEC] : csr_q[S_MTVEC];
		// vectored mode adds 4*cause for interrupts
		tpc = (tvec & rcsr_pkg::TVEC_BASE) +
			((tvec[0] && intr) ? {25'd0, code, 2'b00} : 32'd0);
		if (trap == rcsr_pkg::TRAP_NONE) tpc = 32'd0;
	end

	// next state of the store and privilege
	always_comb begin
		for (int i = 0; i < CSR_COUNT; i++) nx[i] = csr_q[i];
		priv_n = priv_q;
		ret = 1'b0;
		rpc = 32'd0;
		ms_n = ms;
		if (r.cmd == rcsr_pkg::CMD_WRITE) begin
			case (r.csr_number)
				rcsr_pkg::A_MIE: nx[S_MIE] = wval & rcsr_pkg::M_INT_BITS;
				rcsr_pkg::A_SIE: nx[S_MIE] = (csr_q[S_MIE] & ~rcsr_pkg::S_INT_BITS) |
					(wval & rcsr_pkg::S_INT_BITS);
				rcsr_pkg::A_MIP: nx[S_MIP] = wval & rcsr_pkg::M_INT_BITS;
				rcsr_pkg::A_SIP: nx[S_MIP] = (csr_q[S_MIP] & ~rcsr_pkg::S_INT_BITS) |
					(wval & rcsr_pkg::S_INT_BITS);
				rcsr_pkg::A_MSTATUS: begin
					ms_n = (ms & ~rcsr_pkg::MSTATUS_WMASK) |
						(wval & rcsr_pkg::MSTATUS_WMASK);
					// drop the reserved MPP encoding
					if (ms_n[12:11] == 2'b10) ms_n[12:11] = 2'b00;
					nx[S_MSTATUS] = ms_n;
				end
				rcsr_pkg::A_SSTATUS: nx[S_MSTATUS] = (ms & ~rcsr_pkg::S_STATUS_BITS) |
					(wval & rcsr_pkg::S_STATUS_BITS);
				default: if (slot_ok) nx[slot] = wval;
			endcase
		end else if (r.cmd == rcsr_pkg::CMD_RETIRE) begin
			if (trap == rcsr_pkg::TRAP_M) begin
				nx[S_MEPC] = r.pc;
				nx[S_MCAUSE] = {intr, 26'd0, code};
				nx[S_MTVAL] = tval;
				ms_n[12:11] = priv_q;
				ms_n[7] = ms[3];
				ms_n[3] = 1'b0;
				nx[S_MSTATUS] = ms_n;
				priv_n = rcsr_pkg::PRIV_M;
			end else if (trap == rcsr_pkg::TRAP_S) begin
				nx[S_SEPC] = r.pc;
				nx[S_SCAUSE] = {intr, 26'd0, code};
				nx[S_STVAL] = tval;
				ms_n[8] = priv_q == rcsr_pkg::PRIV_S;
				ms_n[5] = ms[1];
				ms_n[1] = 1'b0;
				nx[S_MSTATUS] = ms_n;
				priv_n = rcsr_pkg::PRIV_S;
			end else if (r.event_kind == rcsr_pkg::EV_MRET) begin
				ms_n[3] = ms[7];
				priv_n = (ms[12:11] == 2'b10) ? rcsr_pkg::PRIV_U : ms[12:11];
				ms_n[7] = 1'b1;
				ms_n[12:11] = 2'b00;
				nx[S_MSTATUS] = ms_n;
				ret = 1'b1;
				rpc = csr_q[S_MEPC];
			end else if (r.event_kind == rcsr_pkg::EV_SRET) begin
				ms_n[1] = ms[5];
				priv_n = {1'b0, ms[8]};
				ms_n[5] = 1'b1;
				ms_n[8] = 1'b0;
				nx[S_MSTATUS] = ms_n;
				ret = 1'b1;
				rpc = csr_q[S_SEPC];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CSR_COUNT; i++) csr_q[i] <= 32'd0;
			priv_q <= rcsr_pkg::PRIV_M;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				for (int i = 0; i < CSR_COUNT; i++) csr_q[i] <= nx[i];
				priv_q <= priv_n;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.read_data <= (r.cmd == rcsr_pkg::CMD_READ) ? rd_val : 32'd0;
			out_q.irq_pending <= m_any || s_any;
			out_q.trap_taken <= trap;
			out_q.trap_pc <= tpc;
			out_q.return_taken <= ret;
			out_q.return_pc <= rpc;
			out_q.privilege_now <= priv_n;
			out_q.status_now <= nx[S_MSTATUS];
			out_q.satp_now <= nx[S_SATP];
		end
	end

	a_priv_legal: assert property (@(posedge clk) disable iff (!arst_n)
		priv_q != 2'b10) else $error("reserved privilege");
	a_trap_mach: assert property (@(posedge clk) disable iff (!arst_n)
		accept && trap == rcsr_pkg::TRAP_M |=> priv_q == rcsr_pkg::PRIV_M)
		else $error("machine trap left wrong privilege");
	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.return_taken && out_q.trap_taken != rcsr_pkg::TRAP_NONE))
		else $error("trap and return together");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |=> out_valid_q && $stable(out_q))
		else $error("result lost under stall");
endmodule
`default_nettype wire

### bench/tb_channels.sv
// Testbench-side view of the CSR trap unit channels: no extra interfaces needed,
// the RTL interfaces rcsr_req_if and rcsr_rsp_if are used directly.
// Depends on rcsr_pkg.
`default_nettype none
package tb_csr_types;
	import rcsr_pkg::*;
	typedef struct {
		req_t req;
		bit   check_fixed;
		rsp_t fixed;
	} stim_row_t;
endpackage
`default_nettype wire

### bench/testbench.sv
// Self-checking bench for rv32_csr_trap_unit: a directed table and random
// retire/CSR traffic, checked against a behavioral CSR and trap predictor.
// Depends on rcsr_pkg, tb_csr_types, rcsr_req_if, rcsr_rsp_if and the RTL top.
`default_nettype none
module testbench;
	import rcsr_pkg::*;
	import tb_csr_types::*;

	localparam int N_RANDOM = 2000;
	localparam int CYCLE_LIMIT = 200000;

	// predictor state slots
	localparam int R_MSTATUS = 0, R_MIE = 1, R_MIP = 2, R_MIDELEG = 3, R_MEDELEG = 4;
	localparam int R_MTVEC = 5, R_STVEC = 6, R_MEPC = 7, R_SEPC = 8, R_MCAUSE = 9;
	localparam int R_SCAUSE = 10, R_MTVAL = 11, R_STVAL = 12, R_SATP = 13;
	localparam int R_MSCRATCH = 14, R_SSCRATCH = 15;

	localparam logic [31:0] ST_SIE = 32'h2, ST_MIE = 32'h8, ST_SPIE = 32'h20;
	localparam logic [31:0] ST_MPIE = 32'h80, ST_SPP = 32'h100, ST_MPP = 32'h1800;
	localparam logic [31:0] IP_SSIP = 32'h2, IP_MSIP = 32'h8, IP_STIP = 32'h20;
	localparam logic [31:0] IP_MTIP = 32'h80, IP_SEIP = 32'h200, IP_MEIP = 32'h800;
	localparam logic [1:0] OP_PLAIN = 2'd0;
	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [1:0] CMD_NOP = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	rcsr_req_if req_ch ();
	rcsr_rsp_if rsp_ch ();

	rv32_csr_trap_unit dut (.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source));

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [31:0] csr_q [16];
	logic [1:0]  priv_q;
	rsp_t        expected_rsp_q [$];
	bit          fixed_q [$];
	rsp_t        fixed_rsp_q [$];
	int          mismatches = 0;
	int          beats_seen = 0;
	int          traps_seen = 0;
	int          returns_seen = 0;
	stim_row_t   directed [$];

	function automatic int slot_for(logic [11:0] num);
		case (num)
			A_MSTATUS:  return R_MSTATUS;
			A_MIE:      return R_MIE;
			A_MIP:      return R_MIP;
			A_MIDELEG:  return R_MIDELEG;
			A_MEDELEG:  return R_MEDELEG;
			A_MTVEC:    return R_MTVEC;
			A_STVEC:    return R_STVEC;
			A_MEPC:     return R_MEPC;
			A_SEPC:     return R_SEPC;
			A_MCAUSE:   return R_MCAUSE;
			A_SCAUSE:   return R_SCAUSE;
			A_MTVAL:    return R_MTVAL;
			A_STVAL:    return R_STVAL;
			A_SATP:     return R_SATP;
			A_MSCRATCH: return R_MSCRATCH;
			A_SSCRATCH: return R_SSCRATCH;
			default:    return -1;
		endcase
	endfunction

	function automatic logic [31:0] csr_value(logic [11:0] num);
		int s;
		s = slot_for(num);
		if (num == A_SSTATUS) return csr_q[R_MSTATUS] & S_STATUS_BITS;
		if (num == A_SIE) return csr_q[R_MIE] & S_INT_BITS;
		if (num == A_SIP) return csr_q[R_MIP] & S_INT_BITS;
		if (num == A_MISA) return MISA_VALUE;
		return (s < 0) ? 32'h0 : csr_q[s];
	endfunction

	function automatic logic [31:0] handler_pc(logic [31:0] tvec, bit intr, logic [31:0] code);
		logic [31:0] base;
		base = tvec & TVEC_BASE;
		if (tvec[0] && intr) base += 32'd4 * (code & CODE_MASK);
		return base;
	endfunction

	// Advance the predicted CSR/privilege state by one beat and return its result.
	function automatic rsp_t csr_unit_step(req_t r);
		rsp_t o;
		logic [31:0] ms, pend, mid, oldv, v, code, tval;
		logic [1:0] trap;
		bit m_en, s_en, msw, mt, me, ssw, st, se, m_any, s_any, intr;
		int s;
		ms = csr_q[R_MSTATUS];
		pend = csr_q[R_MIP] & csr_q[R_MIE];
		mid = csr_q[R_MIDELEG];
		m_en = priv_q != PRIV_M || (ms & ST_MIE) != 0;
		s_en = priv_q == PRIV_U || (priv_q == PRIV_S && (ms & ST_SIE) != 0);
		msw = (pend & IP_MSIP) != 0 && (mid & IP_MSIP) == 0 && m_en;
		mt = (pend & IP_MTIP) != 0 && (mid & IP_MTIP) == 0 && m_en;
		me = (pend & IP_MEIP) != 0 && (mid & IP_MEIP) == 0 && m_en;
		ssw = (((pend & mid & IP_MSIP) != 0) || (pend & IP_SSIP) != 0) && s_en;
		st = (((pend & mid & IP_MTIP) != 0) || (pend & IP_STIP) != 0) && s_en;
		se = (((pend & mid & IP_MEIP) != 0) || (pend & IP_SEIP) != 0) && s_en;
		m_any = msw || mt || me;
		s_any = ssw || st || se;
		o = '0;
		trap = TRAP_NONE;
		intr = 0;
		code = 0;
		tval = 0;
		case (r.cmd)
			CMD_READ: o.read_data = csr_value(r.csr_number);
			CMD_WRITE: begin
				oldv = csr_value(r.csr_number);
				v = (r.write_op == OP_SET) ? (oldv | r.data) :
					(r.write_op == OP_CLEAR) ? (oldv & ~r.data) : r.data;
				case (r.csr_number)
					A_MIE: csr_q[R_MIE] = v & M_INT_BITS;
					A_SIE: csr_q[R_MIE] = (csr_q[R_MIE] & ~S_INT_BITS) | (v & S_INT_BITS);
					A_MIP: csr_q[R_MIP] = v & M_INT_BITS;
					A_SIP: csr_q[R_MIP] = (csr_q[R_MIP] & ~S_INT_BITS) | (v & S_INT_BITS);
					A_MSTATUS: begin
						v = (ms & ~MSTATUS_WMASK) | (v & MSTATUS_WMASK);
						// reserved MPP value falls back to user
						if ((v & ST_MPP) == 32'h1000) v &= ~ST_MPP;
						csr_q[R_MSTATUS] = v;
					end
					A_SSTATUS: csr_q[R_MSTATUS] = (ms & ~S_STATUS_BITS) | (v & S_STATUS_BITS);
					default: begin
						s = slot_for(r.csr_number);
						if (s >= 0) csr_q[s] = v;
					end
				endcase
			end
			CMD_RETIRE: begin
				if (r.irq_take && (m_any || s_any)) begin
					intr = 1;
					if (m_any) begin
						trap = TRAP_M;
						code = msw ? 3 : mt ? 7 : 11;
					end else begin
						trap = TRAP_S;
						code = se ? 9 : st ? 5 : 1;
					end
				end else if (r.event_kind >= EV_ECALL && r.event_kind <= EV_ILL) begin
					case (r.event_kind)
						EV_ECALL:  code = (priv_q == PRIV_U) ? 8 : (priv_q == PRIV_S) ? 9 : 11;
						EV_IFAULT: code = 12;
						EV_LFAULT: code = 13;
						EV_SFAULT: code = 15;
						default:   code = 2;
					endcase
					if (r.event_kind != EV_ECALL) tval = r.data;
					trap = (priv_q != PRIV_M && code != 11 && csr_q[R_MEDELEG][code[4:0]])
						? TRAP_S : TRAP_M;
				end
				if (trap == TRAP_M) begin
					csr_q[R_MEPC] = r.pc;
					csr_q[R_MCAUSE] = {intr, code[30:0]};
					csr_q[R_MTVAL] = tval;
					o.trap_pc = handler_pc(csr_q[R_MTVEC], intr, code);
					ms = (ms & ~ST_MPP) | (32'(priv_q) << 11);
					ms = (ms & ST_MIE) != 0 ? (ms | ST_MPIE) : (ms & ~ST_MPIE);
					csr_q[R_MSTATUS] = ms & ~ST_MIE;
					priv_q = PRIV_M;
				end else if (trap == TRAP_S) begin
					csr_q[R_SEPC] = r.pc;
					csr_q[R_SCAUSE] = {intr, code[30:0]};
					csr_q[R_STVAL] = tval;
					o.trap_pc = handler_pc(csr_q[R_STVEC], intr, code);
					ms = (priv_q == PRIV_S) ? (ms | ST_SPP) : (ms & ~ST_SPP);
					ms = (ms & ST_SIE) != 0 ? (ms | ST_SPIE) : (ms & ~ST_SPIE);
					csr_q[R_MSTATUS] = ms & ~ST_SIE;
					priv_q = PRIV_S;
				end else if (r.event_kind == EV_MRET) begin
					ms = (ms & ST_MPIE) != 0 ? (ms | ST_MIE) : (ms & ~ST_MIE);
					priv_q = ms[12:11];
					if (priv_q == 2'd2) priv_q = PRIV_U;
					csr_q[R_MSTATUS] = (ms | ST_MPIE) & ~ST_MPP;
					o.return_taken = 1;
					o.return_pc = csr_q[R_MEPC];
				end else if (r.event_kind == EV_SRET) begin
					ms = (ms & ST_SPIE) != 0 ? (ms | ST_SIE) : (ms & ~ST_SIE);
					priv_q = {1'b0, ms[8]};
					csr_q[R_MSTATUS] = (ms | ST_SPIE) & ~ST_SPP;
					o.return_taken = 1;
					o.return_pc = csr_q[R_SEPC];
				end
			end
			default: ;
		endcase
		o.irq_pending = m_any || s_any;
		o.trap_taken = trap;
		o.privilege_now = priv_q;
		o.status_now = csr_q[R_MSTATUS];
		o.satp_now = csr_q[R_SATP];
		return o;
	endfunction

	function automatic req_t make_req(logic [1:0] c, logic [11:0] n, logic [1:0] op,
			logic [31:0] d, logic [31:0] p, logic [2:0] ev, logic ir);
		req_t r;
		r.cmd = c; r.csr_number = n; r.write_op = op; r.data = d;
		r.pc = p; r.event_kind = ev; r.irq_take = ir;
		return r;
	endfunction

	function automatic void add_row(req_t r);
		stim_row_t row;
		row.req = r; row.check_fixed = 0; row.fixed = '0;
		directed.push_back(row);
	endfunction

	// Rows whose result is obvious: reads straight after reset.
	function automatic void add_read_row(logic [11:0] n, logic [31:0] value);
		stim_row_t row;
		row.req = make_req(CMD_READ, n, OP_PLAIN, '0, '0, EV_NONE, 0);
		row.check_fixed = 1;
		row.fixed = '0;
		row.fixed.read_data = value;
		row.fixed.privilege_now = PRIV_M;
		directed.push_back(row);
	endfunction

	function automatic void build_directed();
		add_read_row(A_MISA, MISA_VALUE);
		add_read_row(A_MSTATUS, 32'h0);
		add_read_row(12'hfff, 32'h0);
		add_row(make_req(CMD_WRITE, A_MISA, OP_PLAIN, 32'hffffffff, '0, EV_NONE, 0));
		add_row(make_req(CMD_WRITE, 12'h7c0, OP_PLAIN, 32'hffffffff, '0, EV_NONE, 0));
		add_row(make_req(CMD_WRITE, A_MSTATUS, 2'd3, 32'hffffffff, '0, EV_NONE, 0));
		add_row(make_req(CMD_WRITE, A_MSTATUS, OP_PLAIN, 32'h00001008, '0, EV_NONE, 0));
		add_row(make_req(CMD_WRITE, A_MTVEC, OP_PLAIN, 32'h80000001, '0, EV_NONE, 0));
		add_row(make_req(CMD_WRITE, A_STVEC, OP_PLAIN, 32'h40000001, '0, EV_NONE, 0));
		add_row(make_req(CMD_WRITE, A_MEDELEG, OP_PLAIN, 32'hffffffff, '0, EV_NONE, 0));
		add_row(make_req(CMD_RETIRE, '0, OP_PLAIN, 32'hdeadbeef, 32'hfffffffc, EV_ECALL, 0));
		add_row(make_req(CMD_RETIRE, '0, OP_PLAIN, 32'h12345678, 32'h100, EV_ILL, 0));
		add_row(make_req(CMD_RETIRE, '0, OP_PLAIN, '0, '0, EV_MRET, 0));
		add_row(make_req(CMD_RETIRE, '0, OP_PLAIN, 32'hffffffff, 32'h200, EV_LFAULT, 0));
		add_row(make_req(CMD_RETIRE, '0, OP_PLAIN, '0, 32'h204, EV_SFAULT, 0));
		add_row(make_req(CMD_RETIRE, '0, OP_PLAIN, '0, 32'h208, EV_IFAULT, 0));
		add_row(make_req(CMD_RETIRE, '0, OP_PLAIN, '0, '0, EV_SRET, 0));
		add_row(make_req(CMD_WRITE, A_MIE, OP_SET, 32'hffffffff, '0, EV_NONE, 0));
		add_row(make_req(CMD_WRITE, A_MIP, OP_PLAIN, 32'h00000888, '0, EV_NONE, 0));
		add_row(make_req(CMD_RETIRE, '0, OP_PLAIN, '0, 32'h300, EV_ECALL, 1));
		add_row(make_req(CMD_WRITE, A_MIDELEG, OP_PLAIN, 32'hffffffff, '0, EV_NONE, 0));
		add_row(make_req(CMD_WRITE, A_SIP, OP_CLEAR, 32'h00000222, '0, EV_NONE, 0));
		add_row(make_req(CMD_RETIRE, '0, OP_PLAIN, '0, 32'h304, EV_NONE, 1));
		add_row(make_req(CMD_NOP, 12'hfff, 2'd3, 32'hffffffff, 32'hffffffff, 3'd7, 1));
		add_row(make_req(CMD_READ, A_SSTATUS, OP_PLAIN, '0, '0, EV_NONE, 0));
	endfunction

	// Random beat weighted toward known CSR numbers; event kinds are drawn uniformly.
	function automatic req_t random_req();
		logic [11:0] known [20];
		req_t r;
		known = '{A_SSTATUS, A_SIE, A_STVEC, A_SSCRATCH, A_SEPC, A_SCAUSE, A_STVAL, A_SIP,
			A_SATP, A_MSTATUS, A_MISA, A_MEDELEG, A_MIDELEG, A_MIE, A_MTVEC, A_MSCRATCH,
			A_MEPC, A_MCAUSE, A_MTVAL, A_MIP};
		r.cmd = ($urandom_range(0, 19) == 0) ? CMD_NOP : 2'($urandom_range(0, 2));
		r.csr_number = ($urandom_range(0, 9) == 0) ? 12'($urandom) : known[$urandom_range(0, 19)];
		r.write_op = 2'($urandom);
		case ($urandom_range(0, 3))
			0: r.data = $urandom;
			1: r.data = 32'($urandom) & 32'h00000bbb;
			2: r.data = {$urandom_range(0, 1) ? 32'hffffffff : 32'h0};
			default: r.data = 32'($urandom) & 32'h00001fab;
		endcase
		r.pc = $urandom;
		r.event_kind = 3'($urandom);
		r.irq_take = 1'($urandom);
		return r;
	endfunction

	// Present one beat, hold it until accepted, and record what it should produce.
	// Drop valid only for a real gap so back-to-back beats keep it high.
	task automatic send_beat(req_t r, bit has_fixed, rsp_t fixed_val);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.payload <= r;
		req_ch.valid <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		expected_rsp_q.push_back(csr_unit_step(r));
		fixed_q.push_back(has_fixed);
		fixed_rsp_q.push_back(fixed_val);
		@(negedge clk);
	endtask

	function automatic void report(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch beat %0d %s: expected %h got %h", beats_seen, what, want, got);
	endfunction

	function automatic void compare_rsp(rsp_t want, rsp_t got);
		if (got.read_data !== want.read_data) report("read_data", want.read_data, got.read_data);
		if (got.irq_pending !== want.irq_pending)
			report("irq_pending", want.irq_pending, got.irq_pending);
		if (got.trap_taken !== want.trap_taken) report("trap_taken", want.trap_taken, got.trap_taken);
		if (got.trap_pc !== want.trap_pc) report("trap_pc", want.trap_pc, got.trap_pc);
		if (got.return_taken !== want.return_taken)
			report("return_taken", want.return_taken, got.return_taken);
		if (got.return_pc !== want.return_pc) report("return_pc", want.return_pc, got.return_pc);
		if (got.privilege_now !== want.privilege_now)
			report("privilege_now", want.privilege_now, got.privilege_now);
		if (got.status_now !== want.status_now) report("status_now", want.status_now, got.status_now);
		if (got.satp_now !== want.satp_now) report("satp_now", want.satp_now, got.satp_now);
	endfunction

	// Result side: random stalls, in-order compare against the oldest prediction.
	initial begin
		rsp_t want, fixed_val;
		bit has_fixed;
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			beats_seen++;
			if (expected_rsp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %0d", beats_seen);
			end else begin
				want = expected_rsp_q.pop_front();
				has_fixed = fixed_q.pop_front();
				fixed_val = fixed_rsp_q.pop_front();
				compare_rsp(want, rsp_ch.payload);
				// typed-in values double-check the predictor itself
				if (has_fixed) compare_rsp(fixed_val, rsp_ch.payload);
				if (rsp_ch.payload.trap_taken != TRAP_NONE) traps_seen++;
				if (rsp_ch.payload.return_taken) returns_seen++;
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		req_t r;
		int tail;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		for (int i = 0; i < 16; i++) csr_q[i] = '0;
		priv_q = PRIV_M;
		build_directed();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (directed[i]) send_beat(directed[i].req, directed[i].check_fixed, directed[i].fixed);
		for (int i = 0; i < N_RANDOM; i++) begin
			r = random_req();
			send_beat(r, 0, '0);
		end
		req_ch.valid <= 1'b0;
		// drain: wait for every prediction to be matched, then a short tail
		while (expected_rsp_q.size() != 0) @(posedge clk);
		tail = 0;
		while (tail < 20) begin
			@(posedge clk);
			tail++;
		end
		$display("ran %0d beats (%0d directed), %0d traps and %0d returns observed",
			beats_seen, directed.size(), traps_seen, returns_seen);
		if (mismatches == 0 && expected_rsp_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire
